[src/lirp_pkg.sv]
`default_nettype none

package lirp_pkg;

  localparam int unsigned RATE_W          = 18;
  localparam int unsigned DEF_MAX_RATIO   = 16;
  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_THROUGH = 2'd2;

  localparam logic [RATE_W-1:0] RST_INPUT_RATE  = 18'd8000;
  localparam logic [RATE_W-1:0] RST_OUTPUT_RATE = 18'd48000;

  // handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_stat_t;

endpackage

`default_nettype wire

[src/lirp_div.sv]
`default_nettype none

// signed numerator over unsigned rate, one quotient bit per cycle,
// truncated toward zero; the quotient magnitude must fit SAMPLE_BITS bits
module lirp_div #(
  parameter int unsigned SAMPLE_BITS = lirp_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned NUM_W       = lirp_pkg::DEF_SAMPLE_BITS + lirp_pkg::RATE_W + 2
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  lirp_pkg::div_req_t                  req_i,
  input  wire  logic signed [NUM_W-1:0]       num_i,
  input  wire  logic [lirp_pkg::RATE_W-1:0]   den_i,
  output lirp_pkg::div_stat_t                 stat_o,
  output logic signed [SAMPLE_BITS-1:0]       quot_o
);

  localparam int unsigned RW    = lirp_pkg::RATE_W;
  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS + 1);

  logic                   busy_q, busy_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [RW-1:0]          rem_q, rem_d;
  logic [SAMPLE_BITS-1:0] quo_q, quo_d;
  logic                   neg_q, neg_d;

  logic [NUM_W-1:0]       mag;
  logic [RW:0]            trial;
  logic                   fits;

  assign mag   = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign trial = {rem_q, quo_q[SAMPLE_BITS-1]};
  assign fits  = trial >= {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SAMPLE_BITS);
      rem_d  = mag[SAMPLE_BITS +: RW];
      quo_d  = mag[SAMPLE_BITS-1:0];
      neg_d  = num_i[NUM_W-1];
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        rem_d = fits ? RW'(trial - {1'b0, den_i}) : trial[RW-1:0];
        quo_d = {quo_q[SAMPLE_BITS-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == '0);
  assign quot_o      = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

[src/linear_interp_upsampler.sv]
`default_nettype none

// channel  | direction | handshake              | payload
// input    | in        | in_valid_i / in_stall_o   | sample_i, frame_end_i
// output   | out       | out_valid_o / out_stall_i | out_sample_o, last_o, rate_error_o
// config   | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// one item at a time: in_stall_o is low only while the sequencer is idle.
// pass-through, equal rates or a bad ratio: each item goes straight to the bypass emit state.
// each interpolated output goes through the shared multiplier (two passes)
// and the bit-serial divider before its emit state; each repeated tail
// output goes through the tail and tail emit states.
// a stalled output register holds the sequencer in its emit state.
// reset clears the rates to their defaults and the frame state.
module linear_interp_upsampler #(
  parameter int unsigned MAX_RATIO   = lirp_pkg::DEF_MAX_RATIO,
  parameter int unsigned SAMPLE_BITS = lirp_pkg::DEF_SAMPLE_BITS
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  wire                                   frame_end_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]         out_sample_o,
  output logic                                  last_o,
  output logic                                  rate_error_o,
  input  wire                                   cfg_we_i,
  input  wire  logic [lirp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  logic [lirp_pkg::RATE_W-1:0]     cfg_data_i
);

  localparam int unsigned RW      = lirp_pkg::RATE_W;
  localparam int unsigned PH_W    = RW + 2;
  localparam int unsigned NUM_W   = SAMPLE_BITS + RW + 2;
  localparam int unsigned PROD_W  = SAMPLE_BITS + RW + 1;
  localparam int unsigned RATIO_W = $clog2(MAX_RATIO + 1);
  localparam int unsigned LIM_W   = RW + RATIO_W;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_LOOP      = 10'b0000000010,
    S_MULA      = 10'b0000000100,
    S_MULB      = 10'b0000001000,
    S_DLOAD     = 10'b0000010000,
    S_DIV       = 10'b0000100000,
    S_EMIT_INT  = 10'b0001000000,
    S_TAIL      = 10'b0010000000,
    S_EMIT_TAIL = 10'b0100000000,
    S_EMIT_BYP  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [RW-1:0] ir_q, ir_d;
  logic [RW-1:0] or_q, or_d;
  logic          pass_q, pass_d;

  // frame state
  logic                          have_prev_q, have_prev_d;
  logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [RW-1:0]                 phase_q, phase_d;

  // per item working registers
  logic signed [SAMPLE_BITS-1:0] b_q, b_d;
  logic                          fe_q, fe_d;
  logic                          err_q, err_d;
  logic [PH_W-1:0]               ph_q, ph_d;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [NUM_W-1:0]       num_q, num_d;
  logic signed [SAMPLE_BITS-1:0] res_q, res_d;

  // output register
  logic                          ovalid_q, ovalid_d;
  logic signed [SAMPLE_BITS-1:0] osample_q, osample_d;
  logic                          olast_q, olast_d;
  logic                          oerr_q, oerr_d;

  logic [LIM_W-1:0]              ir_lim;
  logic                          bad;
  logic                          bypass;
  logic                          out_free;
  logic [PH_W-1:0]               ir_ext, or_ext;
  logic [PH_W-1:0]               nxt;
  logic [PH_W-1:0]               ph_sub;
  logic                          last_int;
  logic                          last_tail;
  logic                          tail_more;

  logic signed [SAMPLE_BITS-1:0] mul_x;
  logic [RW-1:0]                 mul_y;
  logic signed [PROD_W-1:0]      mul_p;

  lirp_pkg::div_req_t            div_req;
  lirp_pkg::div_stat_t           div_stat;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  lirp_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NUM_W       (NUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (num_q),
    .den_i  (or_q),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  assign ir_lim = LIM_W'(ir_q) * LIM_W'(MAX_RATIO);
  assign bad    = (ir_q == '0) || (or_q < ir_q) || (LIM_W'(or_q) > ir_lim);
  assign bypass = pass_q || bad || (ir_q == or_q);

  assign out_free = !ovalid_q || !out_stall_i;
  assign ir_ext   = PH_W'(ir_q);
  assign or_ext   = PH_W'(or_q);
  assign nxt      = ph_q + ir_ext;
  assign ph_sub   = have_prev_q ? PH_W'(ph_q - or_ext) : '0;

  // last interpolated output of a frame only if the tail adds nothing
  assign last_int  = fe_q && (nxt >= or_ext) && (PH_W'(nxt - or_ext + ir_ext) > or_ext);
  assign last_tail = PH_W'(nxt + ir_ext) > or_ext;
  assign tail_more = nxt <= or_ext;

  // one multiplier shared by both terms of the weighted sum
  assign mul_x = (state_q == S_MULA) ? prev_q : b_q;
  assign mul_y = (state_q == S_MULA) ? RW'(or_q - ph_q[RW-1:0]) : ph_q[RW-1:0];
  assign mul_p = mul_x * $signed({1'b0, mul_y});

  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    phase_d     = phase_q;
    b_d         = b_q;
    fe_d        = fe_q;
    err_d       = err_q;
    ph_d        = ph_q;
    prod_d      = prod_q;
    num_d       = num_q;
    res_d       = res_q;
    ovalid_d    = ovalid_q && out_stall_i;
    osample_d   = osample_q;
    olast_d     = olast_q;
    oerr_d      = oerr_q;
    div_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          b_d  = sample_i;
          fe_d = frame_end_i;
          if (bypass) begin
            err_d       = !pass_q && bad;
            have_prev_d = 1'b0;
            phase_d     = '0;
            prev_d      = '0;
            state_d     = S_EMIT_BYP;
          end else begin
            ph_d    = have_prev_q ? PH_W'(phase_q) : '0;
            state_d = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (have_prev_q && (ph_q < or_ext)) begin
          state_d = S_MULA;
        end else begin
          ph_d        = ph_sub;
          prev_d      = b_q;
          have_prev_d = 1'b1;
          if (fe_q) begin
            state_d = S_TAIL;
          end else begin
            phase_d = ph_sub[RW-1:0];
            state_d = S_IDLE;
          end
        end
      end
      S_MULA: begin
        prod_d  = mul_p;
        state_d = S_MULB;
      end
      S_MULB: begin
        num_d   = NUM_W'(prod_q) + NUM_W'(mul_p);
        state_d = S_DLOAD;
      end
      S_DLOAD: begin
        div_req.start = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_d   = div_quot;
          state_d = S_EMIT_INT;
        end
      end
      S_EMIT_INT: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          osample_d = res_q;
          olast_d   = last_int;
          oerr_d    = 1'b0;
          ph_d      = nxt;
          state_d   = S_LOOP;
        end
      end
      S_TAIL: begin
        if (tail_more) begin
          state_d = S_EMIT_TAIL;
        end else begin
          have_prev_d = 1'b0;
          phase_d     = '0;
          state_d     = S_IDLE;
        end
      end
      S_EMIT_TAIL: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          osample_d = b_q;
          olast_d   = last_tail;
          oerr_d    = 1'b0;
          ph_d      = nxt;
          state_d   = S_TAIL;
        end
      end
      S_EMIT_BYP: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          osample_d = b_q;
          olast_d   = fe_q;
          oerr_d    = err_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ir_d   = ir_q;
    or_d   = or_q;
    pass_d = pass_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lirp_pkg::CFG_INPUT_RATE:   ir_d   = cfg_data_i;
        lirp_pkg::CFG_OUTPUT_RATE:  or_d   = cfg_data_i;
        lirp_pkg::CFG_PASS_THROUGH: pass_d = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ir_q        <= lirp_pkg::RST_INPUT_RATE;
      or_q        <= lirp_pkg::RST_OUTPUT_RATE;
      pass_q      <= 1'b0;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      phase_q     <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      ir_q        <= ir_d;
      or_q        <= or_d;
      pass_q      <= pass_d;
      have_prev_q <= have_prev_d;
      prev_q      <= prev_d;
      phase_q     <= phase_d;
      ovalid_q    <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q       <= b_d;
    fe_q      <= fe_d;
    err_q     <= err_d;
    ph_q      <= ph_d;
    prod_q    <= prod_d;
    num_q     <= num_d;
    res_q     <= res_d;
    osample_q <= osample_d;
    olast_q   <= olast_d;
    oerr_q    <= oerr_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = ovalid_q;
  assign out_sample_o = osample_q;
  assign last_o       = olast_q;
  assign rate_error_o = oerr_q;

endmodule

`default_nettype wire

[src/lirp_checker.sv]
`default_nettype none

module lirp_checker #(
  parameter int unsigned SAMPLE_BITS = lirp_pkg::DEF_SAMPLE_BITS
) (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  in_valid_i,
  input wire                                  in_stall_o,
  input wire logic signed [SAMPLE_BITS-1:0]   sample_i,
  input wire                                  frame_end_i,
  input wire                                  out_valid_o,
  input wire                                  out_stall_i,
  input wire logic signed [SAMPLE_BITS-1:0]   out_sample_o,
  input wire                                  last_o,
  input wire                                  rate_error_o,
  input wire                                  cfg_we_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // one item at a time: the input closes right after a transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled after transfer");

  // every result passes through the sequencer, never the same cycle path
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after an input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_sample_o) && $stable(last_o) && $stable(rate_error_o))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(sample_i) && $stable(frame_end_i))
    else $error("stalled input changed");

  // rates only change while the block is empty
  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_stall_o && !out_valid_o)
    else $error("configuration written while busy");

endmodule

bind linear_interp_upsampler lirp_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lirp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .sample_i     (sample_i),
  .frame_end_i  (frame_end_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_sample_o (out_sample_o),
  .last_o       (last_o),
  .rate_error_o (rate_error_o),
  .cfg_we_i     (cfg_we_i)
);

`default_nettype wire

[test/tb_linear_interp_upsampler.sv]
module tb_linear_interp_upsampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SW            = lirp_pkg::DEF_SAMPLE_BITS;
  localparam int unsigned RATIO         = lirp_pkg::DEF_MAX_RATIO;
  localparam int unsigned RW            = lirp_pkg::RATE_W;
  localparam int unsigned IW            = lirp_pkg::CFG_IDX_W;
  localparam int          TOTAL_ITEMS   = 430;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          HOLD_CYCLES   = 600;
  localparam int unsigned CYCLE_LIMIT   = 8_000_000;

  // index with no register behind it
  localparam logic [IW-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic signed [SW-1:0] value;
    logic                 is_last;
    logic                 rate_err;
  } out_word_t;

  class resample_scoreboard;
    logic [RW-1:0]        in_rate;
    logic [RW-1:0]        out_rate;
    logic                 bypass;
    logic signed [SW-1:0] prev_raw;
    bit                   prev_valid;
    bit [31:0]            phase;
    out_word_t            owed[$];
    int                   errors;

    function new();
      in_rate    = lirp_pkg::RST_INPUT_RATE;
      out_rate   = lirp_pkg::RST_OUTPUT_RATE;
      bypass     = 1'b0;
      prev_raw   = '0;
      prev_valid = 1'b0;
      phase      = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [RW-1:0] data);
      case (idx)
        lirp_pkg::CFG_INPUT_RATE:   in_rate = data;
        lirp_pkg::CFG_OUTPUT_RATE:  out_rate = data;
        lirp_pkg::CFG_PASS_THROUGH: bypass = data[0];
        default: ;
      endcase
    endfunction

    function void owe(logic signed [SW-1:0] v, logic l, logic e);
      out_word_t w;
      w.value    = v;
      w.is_last  = l;
      w.rate_err = e;
      owed.push_back(w);
    endfunction

    // works out every output that one accepted sample releases
    function void take_sample(logic signed [SW-1:0] s, logic fe);
      bit [31:0] ir, orr, ph;
      longint    a, b, num;
      int        first;
      bit        bad;
      ir    = 32'(in_rate);
      orr   = 32'(out_rate);
      first = owed.size();
      bad   = (ir == 0) || (orr < ir) || (longint'(orr) > longint'(RATIO) * longint'(ir));
      if (bypass || bad || ir == orr) begin
        owe(s, fe, !bypass && bad);
        prev_valid = 1'b0;
        phase      = '0;
        prev_raw   = '0;
        return;
      end
      b = longint'(s);
      if (prev_valid) begin
        a  = longint'(prev_raw);
        ph = phase;
        while (ph < orr) begin
          num = a * longint'(orr - ph) + b * longint'(ph);
          owe(SW'(num / longint'(orr)), 1'b0, 1'b0);
          ph += ir;
        end
        ph -= orr;
      end else begin
        ph = '0;
      end
      prev_raw   = s;
      prev_valid = 1'b1;
      if (fe) begin
        // outputs still owed at frame end repeat the last sample
        while (longint'(ph) + longint'(ir) <= longint'(orr)) begin
          owe(s, 1'b0, 1'b0);
          ph += ir;
        end
        if (owed.size() > first) owed[owed.size()-1].is_last = 1'b1;
        prev_valid = 1'b0;
        ph         = '0;
      end
      phase = ph & 32'h3FFFF;
    endfunction

    function void check_output(logic signed [SW-1:0] got_value, logic got_last,
                               logic got_err);
      out_word_t want;
      if (owed.size() == 0) begin
        $error("unexpected output: out_sample %0d last %0b rate_error %0b",
               got_value, got_last, got_err);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got_value !== want.value) begin
        $error("out_sample: expected %0d, actual %0d", want.value, got_value);
        errors++;
      end
      if (got_last !== want.is_last) begin
        $error("last: expected %0b, actual %0b", want.is_last, got_last);
        errors++;
      end
      if (got_err !== want.rate_err) begin
        $error("rate_error: expected %0b, actual %0b", want.rate_err, got_err);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic signed [SW-1:0] sample_i     = '0;
  logic                 frame_end_i  = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic signed [SW-1:0] out_sample_o;
  logic                 last_o;
  logic                 rate_error_o;
  logic                 cfg_we_i     = 1'b0;
  logic [IW-1:0]        cfg_idx_i    = '0;
  logic [RW-1:0]        cfg_data_i   = '0;

  resample_scoreboard sb = new();
  int items_sent = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;

  logic signed [SW-1:0] extreme_samples [4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
  logic [RW-1:0]        extreme_rates   [4] = '{18'd1000, 18'd192000, 18'd0, 18'h3FFFF};

  linear_interp_upsampler u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_sample_o (out_sample_o),
    .last_o       (last_o),
    .rate_error_o (rate_error_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial forever #5 clk_i = ~clk_i;

  task automatic send(input logic signed [SW-1:0] s, input logic fe);
    int p, gap;
    in_valid_i  <= 1'b1;
    sample_i    <= s;
    frame_end_i <= fe;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_sample(s, fe);
    items_sent++;
    p   = $urandom_range(0, 99);
    gap = calm ? 0 : (p < 50) ? 0 : (p < 90) ? $urandom_range(1, 3) : $urandom_range(10, 80);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender pauses until every owed output has come out, then lets the block go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [RW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [RW-1:0] ir, input logic [RW-1:0] orr,
                           input logic pt);
    logic [RW-1:0] pt_word;
    pt_word = RW'($urandom);
    pt_word[0] = pt;
    write_reg(lirp_pkg::CFG_INPUT_RATE, ir);
    write_reg(lirp_pkg::CFG_OUTPUT_RATE, orr);
    write_reg(lirp_pkg::CFG_PASS_THROUGH, pt_word);
    cfg_we_i <= 1'b0;
  endtask

  // output side: random stalls plus the long hold-off on request
  initial begin
    int run_left;
    bit stall_now;
    run_left  = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_output(out_sample_o, last_o, rate_error_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_now = 1'b1;
        run_left  = HOLD_CYCLES;
      end else if (run_left > 0) begin
        run_left--;
      end else if (calm) begin
        stall_now = 1'b0;
      end else begin
        stall_now = ($urandom_range(0, 99) < 30);
        if (!stall_now) run_left = $urandom_range(0, 8);
        else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(20, 120);
        else run_left = $urandom_range(0, 3);
      end
      out_stall_i <= stall_now;
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int pick, k, frames, len;
    bit broken;
    logic [RW-1:0] ir, orr;
    logic pt;
    logic signed [SW-1:0] s;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset rates, first sample of a frame gives nothing
    send(16'sh7FFF, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sh0000, 1'b0);
    send(16'shFFFF, 1'b0);
    send(16'sh0001, 1'b1);
    // one-sample frame only repeats
    send(16'sd12345, 1'b1);
    settle();

    configure(18'd8000, 18'd48000, 1'b1);
    send(16'sh8000, 1'b0);
    send(16'sh7FFF, 1'b1);
    settle();
    configure(18'd48000, 18'd48000, 1'b0);
    send(16'shFFFF, 1'b0);
    send(16'sd5, 1'b1);
    settle();
    configure(18'd0, 18'd48000, 1'b0);
    send(16'sd100, 1'b1);
    settle();
    configure(18'd48000, 18'd8000, 1'b0);
    send(-16'sd200, 1'b0);
    settle();
    configure(18'd1000, 18'd16001, 1'b0);
    send(16'sd7, 1'b1);
    settle();
    configure(18'd1000, 18'd16000, 1'b0);
    send(16'sh7FFF, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sh7FFF, 1'b1);
    settle();
    configure(18'd191999, 18'd192000, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sh7FFF, 1'b0);
    send(16'shFFFF, 1'b0);
    send(16'sh0000, 1'b1);
    settle();
    configure(18'h3FFFF, 18'h3FFFF, 1'b0);
    send(16'sh4321, 1'b1);
    settle();
    // rates changed in the middle of a frame
    configure(18'd44100, 18'd48000, 1'b0);
    send(16'sd1000, 1'b0);
    send(-16'sd1000, 1'b0);
    settle();
    configure(18'd8000, 18'd96000, 1'b0);
    send(16'sd20000, 1'b0);
    send(-16'sd20000, 1'b1);
    settle();
    write_reg(CFG_UNUSED, RW'($urandom));
    cfg_we_i <= 1'b0;

    // back-to-back input while the output side holds off
    configure(18'd8000, 18'd48000, 1'b0);
    calm     = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send(SW'($urandom), i == 11);
    settle();
    calm = 1'b0;

    while (items_sent < TOTAL_ITEMS) begin
      settle();
      pick = $urandom_range(0, 99);
      pt   = 1'b0;
      if (pick < 45) begin
        ir  = RW'($urandom_range(1000, 48000));
        orr = RW'($urandom_range(ir, (16 * ir > 192000) ? 192000 : 16 * ir));
      end else if (pick < 60) begin
        k   = $urandom_range(1, RATIO);
        ir  = RW'($urandom_range(1000, 192000 / k));
        orr = RW'(ir * k);
      end else if (pick < 70) begin
        ir  = RW'($urandom);
        orr = RW'($urandom);
        pt  = 1'b1;
      end else if (pick < 80) begin
        ir = RW'($urandom_range(1, 18'h3FFFF));
        if (ir > 16383 || $urandom_range(0, 1)) orr = RW'($urandom_range(0, ir - 1));
        else orr = RW'($urandom_range(16 * ir + 1, 18'h3FFFF));
      end else if (pick < 88) begin
        ir  = RW'($urandom);
        orr = RW'($urandom);
      end else begin
        ir  = extreme_rates[$urandom_range(0, 3)];
        orr = extreme_rates[$urandom_range(0, 3)];
        pt  = ($urandom_range(0, 3) == 0);
      end
      configure(ir, orr, pt);
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) == 0) hold_req = 1'b1;
      frames = $urandom_range(1, 5);
      for (int f = 0; f < frames && items_sent < TOTAL_ITEMS; f++) begin
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
        // an unterminated frame carries its phase into the next setting
        broken = (f == frames - 1) && ($urandom_range(0, 5) == 0);
        for (int i = 0; i < len; i++) begin
          s = ($urandom_range(0, 9) == 0) ? extreme_samples[$urandom_range(0, 3)]
                                          : SW'($urandom);
          send(s, (i == len - 1) && !broken);
        end
        if ($urandom_range(0, 9) == 0) settle();
      end
    end
    calm = 1'b0;
    settle();

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
